// ----- hw/rtl/des_rf_pkg.sv -----
// ----------------------------------------------------------------------------
// des_rf_pkg
// Shared constants, S-box contents and bit permutations for the DES round
// function unit.
// ----------------------------------------------------------------------------
package des_rf_pkg;

  localparam int unsigned HALF_W    = 32;
  localparam int unsigned KEY_W     = 48;
  localparam int unsigned GROUP_W   = 6;
  localparam int unsigned SOUT_W    = 4;
  localparam int unsigned NUM_BOX   = 8;
  localparam int unsigned SBOX_DEPTH = 1 << GROUP_W;
  localparam int unsigned SBOX_AW   = GROUP_W;

  // fill sequencer control toward the s-box memories
  typedef struct packed {
    logic                 we;
    logic [SBOX_AW-1:0]   addr;
  } fill_ctl_t;

  // expansion table, position 1 is the msb
  localparam logic [5:0] E_TAB [KEY_W] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  // straight permutation after the s-boxes
  localparam logic [5:0] P_TAB [HALF_W] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] SBOX_TAB [NUM_BOX][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd5,4'd11,4'd6,4'd3}}
  };

  // s-box entry for a 6-bit group: row from outer bits, column from middle bits
  function automatic logic [SOUT_W-1:0] sbox_value(input int unsigned box,
                                                   input logic [GROUP_W-1:0] grp);
    logic [1:0] row;
    logic [3:0] col;
    row = {grp[5], grp[0]};
    col = grp[4:1];
    return SBOX_TAB[box][row][col];
  endfunction

  // source bit index of a table entry, entry 1 is bit 31
  function automatic logic [4:0] src_bit(input logic [5:0] pos);
    logic [5:0] idx;
    idx = 6'd32 - pos;
    return idx[4:0];
  endfunction

  // e expansion of the right half
  function automatic logic [KEY_W-1:0] e_expand(input logic [HALF_W-1:0] r);
    logic [KEY_W-1:0] x;
    for (int k = 0; k < KEY_W; k++) begin
      x[KEY_W-1-k] = r[src_bit(E_TAB[k])];
    end
    return x;
  endfunction

  // p permutation of the joined s-box outputs
  function automatic logic [HALF_W-1:0] p_perm(input logic [HALF_W-1:0] s);
    logic [HALF_W-1:0] y;
    for (int k = 0; k < HALF_W; k++) begin
      y[HALF_W-1-k] = s[src_bit(P_TAB[k])];
    end
    return y;
  endfunction

endpackage

// ----- hw/rtl/des_rf_ram.sv -----
// ----------------------------------------------------------------------------
// des_rf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module des_rf_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/des_rf_fill.sv -----
// ----------------------------------------------------------------------------
// des_rf_fill
// Load sequencer that writes the s-box contents into the memories after
// reset, one address per cycle.
// ----------------------------------------------------------------------------
module des_rf_fill (
  input  logic                  clk,
  input  logic                  rst_n,
  output des_rf_pkg::fill_ctl_t fill_ctl,
  output logic                  loading
);

  import des_rf_pkg::*;

  logic [SBOX_AW-1:0] addr_r;
  logic [SBOX_AW-1:0] addr_nxt;
  logic               active_r;
  logic               active_nxt;

  // address sweep, stops after the last entry
  always_comb begin
    addr_nxt   = addr_r;
    active_nxt = active_r;
    if (active_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == SBOX_AW'(SBOX_DEPTH - 1)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      active_r <= 1'b1;
    end else begin
      addr_r   <= addr_nxt;
      active_r <= active_nxt;
    end
  end

  assign fill_ctl.we   = active_r;
  assign fill_ctl.addr = addr_r;
  assign loading       = active_r;

endmodule

// ----- hw/rtl/des_round_function_unit.sv -----
// ----------------------------------------------------------------------------
// des_round_function_unit
// DES Feistel f function: E expansion, subkey mix, eight s-box lookups held
// in memories, and the P permutation.
// ----------------------------------------------------------------------------
// One transaction per clock while busy is low: a new right half and subkey
// can be started in every such cycle, and each result appears on
// out_round_output with out_valid high for a single cycle, after the
// registered s-box memory read and the P permutation into the output
// register. The receiver cannot stall the result stream, so nothing ever
// holds the input side back once the unit is ready. After reset the eight
// s-box memories are loaded by a sweep over all 64 addresses, one address
// per cycle; busy stays high during the sweep and low from then on.
// ----------------------------------------------------------------------------
module des_round_function_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [des_rf_pkg::HALF_W-1:0]  in_right_half,
  input  logic [des_rf_pkg::KEY_W-1:0]   in_round_subkey,
  output logic                           out_valid,
  output logic [des_rf_pkg::HALF_W-1:0]  out_round_output
);

  import des_rf_pkg::*;

  localparam int unsigned AW = $clog2(SBOX_DEPTH);

  fill_ctl_t          fill_ctl;
  logic               loading;
  logic               accept;
  logic [KEY_W-1:0]   mixed;
  logic [HALF_W-1:0]  sbox_word;
  logic               lookup_vld_r;
  logic               out_valid_r;
  logic [HALF_W-1:0]  out_data_r;

  // table load after reset
  des_rf_fill u_fill (
    .clk      (clk),
    .rst_n    (rst_n),
    .fill_ctl (fill_ctl),
    .loading  (loading)
  );

  assign busy   = loading;
  assign accept = start && !loading;

  // expansion and key mix feed the memory read addresses
  assign mixed = e_expand(in_right_half) ^ in_round_subkey;

  // one memory per s-box, addressed by its 6-bit group
  for (genvar i = 0; i < NUM_BOX; i++) begin : g_sbox
    logic [GROUP_W-1:0] grp;
    logic [SOUT_W-1:0]  fill_data;

    assign grp       = mixed[(NUM_BOX-1-i)*GROUP_W +: GROUP_W];
    assign fill_data = sbox_value(i, fill_ctl.addr);

    des_rf_ram #(
      .WIDTH (SOUT_W),
      .DEPTH (SBOX_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (fill_ctl.we),
      .waddr (AW'(fill_ctl.addr)),
      .wdata (fill_data),
      .raddr (AW'(grp)),
      .rdata (sbox_word[(NUM_BOX-1-i)*SOUT_W +: SOUT_W])
    );
  end

  // transaction valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lookup_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      lookup_vld_r <= accept;
      out_valid_r  <= lookup_vld_r;
    end
  end

  // p permutation into the output register
  always_ff @(posedge clk) begin
    out_data_r <= p_perm(sbox_word);
  end

  assign out_valid        = out_valid_r;
  assign out_round_output = out_data_r;

endmodule
